FILE: design/spd_pkg.sv
`default_nettype none

package spd_pkg;

  // Default table shape.
  localparam int unsigned NUM_BUCKETS_DEF = 1024;
  localparam int unsigned WAYS_DEF        = 4;

  // Field widths fixed by the word format.
  localparam int unsigned VAL_W       = 31;
  localparam int unsigned CNT_W       = 13;
  localparam int unsigned COUNT_LIMIT = 4096;

  // One stored pair.
  typedef struct packed {
    logic [VAL_W-1:0] first;
    logic [VAL_W-1:0] second;
  } pair_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_RD,
    ST_INS,
    ST_SRCH
  } state_t;

endpackage

`default_nettype wire

FILE: design/symmetric_pair_detector_unit.sv
`default_nettype none

// Channel | Ports                                          | Handshake
// --------+------------------------------------------------+-------------------------------
// input   | in_first_value, in_second_value                | taken when start & ~busy
// result  | out_matched, out_bucket_full, out_match_total  | out_valid, one cycle, no stall
//
// With a power-of-two bucket count the insert row is read as the word is taken, the next
// cycle writes the updated row and reads the search row, and the cycle after that compares
// the ways and may already take the next word. The single read port of the bucket-row
// memory keeps the insert and search row reads apart. Other bucket counts first run the
// 3-stage reciprocal bucket hash, then the row read, and stay busy until the search.
// out_valid is registered from the search cycle. After reset the block clears every
// bucket fill count, one row a cycle, with busy high. Results are never stalled by the
// receiver.

module symmetric_pair_detector_unit #(
  parameter int unsigned NUM_BUCKETS = spd_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned WAYS        = spd_pkg::WAYS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [spd_pkg::VAL_W-1:0] in_first_value,
  input  wire logic [spd_pkg::VAL_W-1:0] in_second_value,
  output logic                           out_valid,
  output logic                           out_matched,
  output logic                           out_bucket_full,
  output logic [spd_pkg::CNT_W-1:0]      out_match_total
);

  localparam int unsigned BKT_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned FILL_W  = $clog2(WAYS + 1);
  localparam bit          IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
  localparam int unsigned CNT_W   = spd_pkg::CNT_W;
  localparam int unsigned VAL_W   = spd_pkg::VAL_W;

  // One memory row is a whole bucket: its fill count and all its ways. A way is only
  // meaningful when its index is below the fill count, so the ways never need clearing.
  typedef struct packed {
    logic [FILL_W-1:0]                fill;
    spd_pkg::pair_t [WAYS-1:0]        way;
  } row_t;

  row_t mem [NUM_BUCKETS];

  spd_pkg::state_t   state_r, state_nxt;
  logic [BKT_W-1:0]  clr_idx_r;
  logic [VAL_W-1:0]  x_r, y_r;
  logic [BKT_W-1:0]  ib_r;
  row_t              rd_row_r;
  row_t              fwd_row_r;
  logic              fwd_r;
  logic              full_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              accept;
  logic              rd_en;
  logic [BKT_W-1:0]  rd_addr;
  logic              wr_en;
  logic [BKT_W-1:0]  wr_addr;
  row_t              wr_row;
  row_t              ins_row;
  logic              ins_full;
  row_t              srch_row;
  logic              hit;
  logic              issue_ins_rd;

  // Bucket indexes from the hash section below.
  logic [BKT_W-1:0]  rd_ins_bkt;
  logic [BKT_W-1:0]  srch_bkt;
  logic              hash_done;

  logic              out_valid_r;
  logic              out_matched_r;
  logic              out_bucket_full_r;
  logic [CNT_W-1:0]  out_match_total_r;

  assign busy   = (state_r == spd_pkg::ST_CLEAR) || (state_r == spd_pkg::ST_HASH) ||
                  (state_r == spd_pkg::ST_RD)    || (state_r == spd_pkg::ST_INS);
  assign accept = start && !busy;

  // Bucket hash. For a power-of-two bucket count this is just the low bits of the value.
  // Otherwise the remainder comes from a reciprocal multiply: q0 = (v * floor(2^31/N)) >> 31
  // is the true quotient or one less, so v - q0*N lies below 2N and one conditional
  // subtract finishes it. Only the low bits of q0*N matter for the remainder.
  generate
    if (IS_POW2) begin : g_pow2
      assign rd_ins_bkt = in_first_value[BKT_W-1:0];
      assign srch_bkt   = y_r[BKT_W-1:0];
      assign hash_done  = 1'b0;
    end else begin : g_recip
      localparam int unsigned      PW      = BKT_W + 1;
      localparam longint unsigned  RECIP_L = (64'd1 << 31) / NUM_BUCKETS;
      localparam logic [VAL_W-1:0] RECIP   = VAL_W'(RECIP_L);
      localparam logic [PW-1:0]    NB_P    = PW'(NUM_BUCKETS);

      logic [2*VAL_W-1:0] p1x_r, p1y_r;
      logic [PW-1:0]      p2x_r, p2y_r;
      logic [BKT_W-1:0]   bkx_r, bky_r;
      logic [PW-1:0]      r0x, r0y;
      logic [1:0]         hcnt_r;

      always_ff @(posedge clk) begin
        p1x_r <= (2*VAL_W)'(x_r) * (2*VAL_W)'(RECIP);
        p1y_r <= (2*VAL_W)'(y_r) * (2*VAL_W)'(RECIP);
        p2x_r <= PW'(p1x_r[VAL_W +: PW] * NB_P);
        p2y_r <= PW'(p1y_r[VAL_W +: PW] * NB_P);
        bkx_r <= BKT_W'((r0x >= NB_P) ? (r0x - NB_P) : r0x);
        bky_r <= BKT_W'((r0y >= NB_P) ? (r0y - NB_P) : r0y);
      end

      always_comb begin
        r0x = x_r[PW-1:0] - p2x_r;
        r0y = y_r[PW-1:0] - p2y_r;
      end

      // The three stages run freely; the counter only times how long the FSM waits.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          hcnt_r <= '0;
        end else if (state_r == spd_pkg::ST_HASH) begin
          hcnt_r <= hash_done ? 2'd0 : hcnt_r + 2'd1;
        end
      end

      assign hash_done  = (hcnt_r == 2'd2);
      assign rd_ins_bkt = bkx_r;
      assign srch_bkt   = bky_r;
    end
  endgenerate

  // Insert: the new pair goes into the first unused way unless the bucket is full.
  always_comb begin
    ins_full = (rd_row_r.fill >= FILL_W'(WAYS));
    ins_row  = rd_row_r;
    if (!ins_full) begin
      for (int w = 0; w < WAYS; w++) begin
        if (FILL_W'(w) == rd_row_r.fill) begin
          ins_row.way[w].first  = x_r;
          ins_row.way[w].second = y_r;
        end
      end
      ins_row.fill = rd_row_r.fill + FILL_W'(1);
    end
  end

  // Search: when the search bucket is the one just written, the memory read returned the
  // old row, so the written row is forwarded instead.
  always_comb begin
    srch_row = fwd_r ? fwd_row_r : rd_row_r;
    hit      = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if ((FILL_W'(w) < srch_row.fill) && (srch_row.way[w].first == y_r) &&
          (srch_row.way[w].second == x_r)) begin
        hit = 1'b1;
      end
    end
    cnt_nxt = cnt_r;
    if (hit && (cnt_r < CNT_W'(spd_pkg::COUNT_LIMIT))) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  // Next state and memory port control.
  always_comb begin
    state_nxt    = state_r;
    rd_en        = 1'b0;
    rd_addr      = rd_ins_bkt;
    wr_en        = 1'b0;
    wr_addr      = ib_r;
    wr_row       = ins_row;
    issue_ins_rd = 1'b0;
    unique case (state_r)
      spd_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx_r;
        wr_row  = '0;
        if (clr_idx_r == BKT_W'(NUM_BUCKETS - 1)) begin
          state_nxt = spd_pkg::ST_IDLE;
        end
      end
      spd_pkg::ST_IDLE, spd_pkg::ST_SRCH: begin
        state_nxt = spd_pkg::ST_IDLE;
        if (accept) begin
          if (IS_POW2) begin
            rd_en        = 1'b1;
            issue_ins_rd = 1'b1;
            state_nxt    = spd_pkg::ST_INS;
          end else begin
            state_nxt = spd_pkg::ST_HASH;
          end
        end
      end
      spd_pkg::ST_HASH: begin
        if (hash_done) begin
          state_nxt = spd_pkg::ST_RD;
        end
      end
      spd_pkg::ST_RD: begin
        rd_en        = 1'b1;
        issue_ins_rd = 1'b1;
        state_nxt    = spd_pkg::ST_INS;
      end
      spd_pkg::ST_INS: begin
        wr_en     = !ins_full;
        rd_en     = 1'b1;
        rd_addr   = srch_bkt;
        state_nxt = spd_pkg::ST_SRCH;
      end
      default: begin
        state_nxt = spd_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spd_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Bucket-row memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= mem[rd_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      fwd_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == spd_pkg::ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + BKT_W'(1);
      end
      fwd_r       <= (state_r == spd_pkg::ST_INS) && !ins_full && (srch_bkt == ib_r);
      out_valid_r <= (state_r == spd_pkg::ST_SRCH);
      if (state_r == spd_pkg::ST_SRCH) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= in_first_value;
      y_r <= in_second_value;
    end
    if (issue_ins_rd) begin
      ib_r <= rd_ins_bkt;
    end
    if (state_r == spd_pkg::ST_INS) begin
      fwd_row_r <= ins_row;
      full_r    <= ins_full;
    end
    if (state_r == spd_pkg::ST_SRCH) begin
      out_matched_r     <= hit;
      out_bucket_full_r <= full_r;
      out_match_total_r <= cnt_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_matched     = out_matched_r;
  assign out_bucket_full = out_bucket_full_r;
  assign out_match_total = out_match_total_r;

`ifndef SYNTH
  // A result only follows a search cycle.
  a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == spd_pkg::ST_SRCH))
    else $error("result strobe without a search cycle");

  // The match count moves only on a search cycle, and then by one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |->
      ($past(state_r == spd_pkg::ST_SRCH) && (cnt_r == $past(cnt_r) + CNT_W'(1))))
    else $error("match count changed outside a search");

  // An insert never writes a row whose bucket is already full.
  a_no_insert_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && (state_r == spd_pkg::ST_INS)) |-> (rd_row_r.fill < FILL_W'(WAYS)))
    else $error("insert into a full bucket");

  // Forwarded rows are only used by the search that follows the insert.
  a_forward_timing: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> (state_r == spd_pkg::ST_SRCH))
    else $error("forwarded row outside a search");
`endif

endmodule

`default_nettype wire
